@@ hdl/hsvrgb_pkg.sv @@
// Shared types and constants for the HSV/HSL to RGB converter.
// Used by every module of the block; depends on nothing else.
package hsvrgb_pkg;

    localparam int HUE_BITS     = 16;
    localparam int CHANNEL_BITS = 8;
    localparam int QUEUE_DEPTH  = 4;

    localparam int RAMP_BITS = HUE_BITS + 1;
    localparam int CN_BITS   = 2 * CHANNEL_BITS;
    localparam int OFF_BITS  = 2 * CHANNEL_BITS + 1;

    localparam logic [CHANNEL_BITS-1:0] CH_FULL = '1;
    localparam logic [RAMP_BITS-1:0]    HUE_ONE = RAMP_BITS'(1) << HUE_BITS;

    localparam logic MODE_HSV = 1'b0;
    localparam logic MODE_HSL = 1'b1;

    localparam logic [2:0] SEXT_RED     = 3'd0;
    localparam logic [2:0] SEXT_YELLOW  = 3'd1;
    localparam logic [2:0] SEXT_GREEN   = 3'd2;
    localparam logic [2:0] SEXT_CYAN    = 3'd3;
    localparam logic [2:0] SEXT_BLUE    = 3'd4;
    localparam logic [2:0] SEXT_MAGENTA = 3'd5;

    typedef struct packed {
        logic                    req_type;
        logic [HUE_BITS-1:0]     hue;
        logic [CHANNEL_BITS-1:0] saturation;
        logic [CHANNEL_BITS-1:0] level;
    } hsx_item_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } rgb_item_t;

    typedef struct packed {
        logic                    hsl;
        logic [2:0]              sext;
        logic [RAMP_BITS-1:0]    ramp;
        logic [CN_BITS-1:0]      cn;
        logic [CHANNEL_BITS-1:0] lvl;
    } work_item_t;

endpackage

@@ hdl/hsvrgb_front.sv @@
// Front end: accepts an item, finds the hue sextant and ramp, and forms chroma times F^2.
// Depends on hsvrgb_pkg; feeds hsvrgb_queue.
module hsvrgb_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  hsvrgb_pkg::hsx_item_t  hsx,
    input  logic                   q_full,
    output logic                   q_push,
    output hsvrgb_pkg::work_item_t q_item
);

    localparam int HB = hsvrgb_pkg::HUE_BITS;
    localparam int CB = hsvrgb_pkg::CHANNEL_BITS;

    logic                   accept;
    logic [HB+2:0]          six;
    logic [2:0]             sext;
    logic [HB-1:0]          frac;
    logic [CB:0]            twol;
    logic [CB:0]            full_x;
    logic [CB:0]            lvl_dist;
    logic [CB-1:0]          chroma_scale;
    logic [CB-1:0]          mult_a;
    hsvrgb_pkg::work_item_t item_next;
    hsvrgb_pkg::work_item_t item_reg;
    logic                   valid_next;
    logic                   valid_reg;

    assign accept = push && !full;
    assign full   = valid_reg && q_full;
    assign q_push = valid_reg && !q_full;
    assign q_item = item_reg;

    always_comb
    begin
        six          = ({3'b000, hsx.hue} << 2) + ({3'b000, hsx.hue} << 1);
        sext         = six[HB+2:HB];
        frac         = six[HB-1:0];
        twol         = {hsx.level, 1'b0};
        full_x       = {1'b0, hsvrgb_pkg::CH_FULL};
        lvl_dist     = (twol >= full_x) ? (twol - full_x) : (full_x - twol);
        chroma_scale = hsvrgb_pkg::CH_FULL - lvl_dist[CB-1:0];
        mult_a       = (hsx.req_type == hsvrgb_pkg::MODE_HSL) ? chroma_scale : hsx.level;

        item_next.hsl  = hsx.req_type;
        item_next.sext = sext;
        item_next.ramp = sext[0] ? (hsvrgb_pkg::HUE_ONE - {1'b0, frac}) : {1'b0, frac};
        item_next.cn   = {{CB{1'b0}}, mult_a} * {{CB{1'b0}}, hsx.saturation};
        item_next.lvl  = hsx.level;
    end

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

@@ hdl/hsvrgb_queue.sv @@
// Short first-in first-out queue of work items between the front and back ends.
// Depends on hsvrgb_pkg for the work item type.
module hsvrgb_queue
#(
    parameter int DEPTH = hsvrgb_pkg::QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  hsvrgb_pkg::work_item_t wr_item,
    input  logic                   pop,
    output logic                   empty,
    output hsvrgb_pkg::work_item_t rd_item
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    hsvrgb_pkg::work_item_t mem [DEPTH];

    logic                push_ok;
    logic                pop_ok;
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [CNT_BITS-1:0] cnt_next;

    assign full    = (cnt_reg == CNT_BITS'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign rd_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !pop_ok)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_BITS'(DEPTH))
        else $error("Queue holds more items than its depth.");

    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push_ok && !pop_ok) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("Queue count missed a write.");

    a_cnt_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_ok && !push_ok) |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("Queue count missed a read.");

endmodule

@@ hdl/hsvrgb_back.sv @@
// Back end: places chroma and ramp into the channels, adds the offset and scales to 0..F.
// Four register stages, the last being the result register. Depends on hsvrgb_pkg.
module hsvrgb_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  hsvrgb_pkg::work_item_t q_item,
    output logic                   q_pop,
    output logic                   empty,
    input  logic                   pop,
    output hsvrgb_pkg::rgb_item_t  rgb
);

    localparam int HB       = hsvrgb_pkg::HUE_BITS;
    localparam int CB       = hsvrgb_pkg::CHANNEL_BITS;
    localparam int OB       = hsvrgb_pkg::OFF_BITS;
    localparam int CN       = hsvrgb_pkg::CN_BITS;
    localparam int RB       = hsvrgb_pkg::RAMP_BITS;
    localparam int EST_BITS = CB + 2;

    localparam logic [1:0] ROLE_ZERO   = 2'd0;
    localparam logic [1:0] ROLE_CHROMA = 2'd1;
    localparam logic [1:0] ROLE_RAMP   = 2'd2;

    localparam logic [OB:0] FULL_1 = {{(OB + 1 - CB){1'b0}}, hsvrgb_pkg::CH_FULL};
    localparam logic [OB:0] FULL_2 = FULL_1 << 1;
    localparam logic [OB:0] FULL_3 = FULL_1 + FULL_2;

    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy4;

    logic          s1_valid_reg;
    logic [OB-1:0] s1_off_reg;
    logic [OB-1:0] s1_xs_reg;
    logic [OB-1:0] s1_cc_reg;
    logic [2:0]    s1_sext_reg;

    logic [CN-1:0]    lvl_f;
    logic [OB-1:0]    off_next;
    logic [CN+RB-1:0] xprod;

    logic          s2_valid_reg;
    logic [OB-1:0] s2_u_reg [3];
    logic [1:0]    role [3];
    logic [OB-1:0] add_term [3];
    logic [OB:0]   t_sum [3];

    logic                s3_valid_reg;
    logic [OB-1:0]       s3_u_reg [3];
    logic [EST_BITS-1:0] s3_e_reg [3];
    logic [OB:0]         est_sum [3];

    logic [OB:0]         e_f [3];
    logic [OB:0]         rem [3];
    logic [EST_BITS-1:0] quo [3];
    logic [CB-1:0]       chan [3];

    logic                  out_valid_reg;
    hsvrgb_pkg::rgb_item_t rgb_reg;
    hsvrgb_pkg::rgb_item_t rgb_next;

    assign rdy4  = !out_valid_reg || pop;
    assign rdy3  = !s3_valid_reg || rdy4;
    assign rdy2  = !s2_valid_reg || rdy3;
    assign rdy1  = !s1_valid_reg || rdy2;
    assign q_pop = !q_empty && rdy1;
    assign empty = !out_valid_reg;
    assign rgb   = rgb_reg;

    // The offset and chroma are held times 2*F^2; the ramp product is pre-scaled by 2/H.
    always_comb
    begin
        lvl_f = {q_item.lvl, {CB{1'b0}}} - {{CB{1'b0}}, q_item.lvl};
        if (q_item.hsl == hsvrgb_pkg::MODE_HSL)
        begin
            off_next = {lvl_f, 1'b0} - {1'b0, q_item.cn};
        end
        else
        begin
            off_next = {lvl_f - q_item.cn, 1'b0};
        end
        xprod = {{RB{1'b0}}, q_item.cn} * {{CN{1'b0}}, q_item.ramp};
    end

    always_comb
    begin
        case (s1_sext_reg)
            hsvrgb_pkg::SEXT_RED:
            begin
                role[0] = ROLE_CHROMA; role[1] = ROLE_RAMP;   role[2] = ROLE_ZERO;
            end
            hsvrgb_pkg::SEXT_YELLOW:
            begin
                role[0] = ROLE_RAMP;   role[1] = ROLE_CHROMA; role[2] = ROLE_ZERO;
            end
            hsvrgb_pkg::SEXT_GREEN:
            begin
                role[0] = ROLE_ZERO;   role[1] = ROLE_CHROMA; role[2] = ROLE_RAMP;
            end
            hsvrgb_pkg::SEXT_CYAN:
            begin
                role[0] = ROLE_ZERO;   role[1] = ROLE_RAMP;   role[2] = ROLE_CHROMA;
            end
            hsvrgb_pkg::SEXT_BLUE:
            begin
                role[0] = ROLE_RAMP;   role[1] = ROLE_ZERO;   role[2] = ROLE_CHROMA;
            end
            default:
            begin
                role[0] = ROLE_CHROMA; role[1] = ROLE_ZERO;   role[2] = ROLE_RAMP;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            case (role[i])
                ROLE_CHROMA: add_term[i] = s1_cc_reg;
                ROLE_RAMP:   add_term[i] = s1_xs_reg;
                default:     add_term[i] = '0;
            endcase
            t_sum[i] = {1'b0, s1_off_reg} + {1'b0, add_term[i]};

            // Quotient by F = 2^CB - 1, estimated low by at most two.
            est_sum[i] = {1'b0, s2_u_reg[i]} + {1'b0, s2_u_reg[i] >> CB};

            e_f[i] = {s3_e_reg[i], {CB{1'b0}}} - {{CB{1'b0}}, s3_e_reg[i]};
            rem[i] = {1'b0, s3_u_reg[i]} - e_f[i];
            if (rem[i] >= FULL_2)
            begin
                quo[i] = s3_e_reg[i] + EST_BITS'(2);
            end
            else if (rem[i] >= FULL_1)
            begin
                quo[i] = s3_e_reg[i] + EST_BITS'(1);
            end
            else
            begin
                quo[i] = s3_e_reg[i];
            end
            chan[i] = (quo[i] > {2'b00, hsvrgb_pkg::CH_FULL}) ? hsvrgb_pkg::CH_FULL
                                                              : quo[i][CB-1:0];
        end
        rgb_next.red   = chan[0];
        rgb_next.green = chan[1];
        rgb_next.blue  = chan[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_valid_reg <= !q_empty;
            end
            if (rdy2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (rdy4)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_off_reg  <= off_next;
            s1_xs_reg   <= xprod[HB-1 +: OB];
            s1_cc_reg   <= {q_item.cn, 1'b0};
            s1_sext_reg <= q_item.sext;
        end
        for (int i = 0; i < 3; i++)
        begin
            if (rdy2)
            begin
                s2_u_reg[i] <= t_sum[i][OB:1];
            end
            if (rdy3)
            begin
                s3_u_reg[i] <= s2_u_reg[i];
                s3_e_reg[i] <= est_sum[i][OB:CB];
            end
        end
        if (rdy4)
        begin
            rgb_reg <= rgb_next;
        end
    end

    a_est_red: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> rem[0] < FULL_3)
        else $error("Red quotient estimate is off by more than two.");

    a_est_green: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> rem[1] < FULL_3)
        else $error("Green quotient estimate is off by more than two.");

    a_est_blue: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> rem[2] < FULL_3)
        else $error("Blue quotient estimate is off by more than two.");

endmodule

@@ hdl/hsv_hsl_to_rgb.sv @@
// Top level of the HSV/HSL to RGB converter.
// Instantiates hsvrgb_front, hsvrgb_queue and hsvrgb_back; depends on hsvrgb_pkg.
//
// Usage: items enter as a queue write. An item is taken at a rising edge with push
// high and full low; hsx carries the model select, hue, saturation and level.
// Results leave as a queue read. While empty is low the oldest result is on rgb,
// and it is taken at a rising edge with pop high.
// Throughput is one item per clock while pop stays high. With no stall, an item
// passes the front register, a queue slot, three arithmetic stages and the result
// register before its result shows on rgb. The one multiplier in the front and the
// one in the back each work on one item per cycle while nothing stalls.
// When pop stays low, the back stages fill, then the queue of QUEUE_DEPTH items,
// then the front register, and only then does full rise; nothing is lost.
// Reset empties every stage and the queue, so empty is high and full is low after
// reset. No item influences the next.
module hsv_hsl_to_rgb
#(
    parameter int QUEUE_DEPTH = hsvrgb_pkg::QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  hsvrgb_pkg::hsx_item_t hsx,
    output logic                  empty,
    input  logic                  pop,
    output hsvrgb_pkg::rgb_item_t rgb
);

    logic                   q_full;
    logic                   q_push;
    hsvrgb_pkg::work_item_t q_wr_item;
    logic                   q_empty;
    logic                   q_pop;
    hsvrgb_pkg::work_item_t q_rd_item;

    hsvrgb_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .hsx    (hsx),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (q_wr_item)
    );

    hsvrgb_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .full    (q_full),
        .wr_item (q_wr_item),
        .pop     (q_pop),
        .empty   (q_empty),
        .rd_item (q_rd_item)
    );

    hsvrgb_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_item  (q_rd_item),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .rgb     (rgb)
    );

endmodule

@@ sim/tb_hsv_hsl_to_rgb.sv @@
// Self-checking testbench for the hsv_hsl_to_rgb color converter.
// Directed and random items go through the queue handshakes under random idling,
// and every result is checked against a predictor. Depends on hsvrgb_pkg and the RTL.
`timescale 1ns / 100ps

module tb_hsv_hsl_to_rgb;

    import hsvrgb_pkg::*;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      pop = 1'b0;
    logic      full;
    logic      empty;
    hsx_item_t hsx = '0;
    rgb_item_t rgb;

    hsx_item_t pending_hsx[$];
    hsx_item_t in_flight_hsx[$];
    int        tx_idle = 28;
    int        rx_idle = 61;
    int        fault_count = 0;

    hsv_hsl_to_rgb dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .hsx   (hsx),
        .empty (empty),
        .pop   (pop),
        .rgb   (rgb)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [CHANNEL_BITS-1:0] scale_channel(longint unsigned num);
        longint unsigned v;
        v = num / (longint'(2) * longint'(CH_FULL) * (longint'(1) << HUE_BITS));
        if (v > longint'(CH_FULL))
        begin
            v = longint'(CH_FULL);
        end
        return v[CHANNEL_BITS-1:0];
    endfunction

    function automatic rgb_item_t convert_hsx(hsx_item_t it);
        longint unsigned full_scale;
        longint unsigned turn;
        longint unsigned six;
        longint unsigned frac;
        longint unsigned ramp;
        longint unsigned twol;
        longint unsigned lvl_dev;
        longint unsigned cn;
        longint unsigned chroma;
        longint unsigned xval;
        longint unsigned offset;
        longint unsigned r;
        longint unsigned g;
        longint unsigned b;
        logic [2:0]      sext;
        rgb_item_t       res;
        full_scale = longint'(CH_FULL);
        turn = longint'(1) << HUE_BITS;
        six = longint'(it.hue) * 6;
        sext = 3'(six >> HUE_BITS);
        frac = six & (turn - 1);
        ramp = sext[0] ? turn - frac : frac;
        if (it.req_type == MODE_HSL)
        begin
            twol = 2 * longint'(it.level);
            lvl_dev = (twol >= full_scale) ? twol - full_scale : full_scale - twol;
            cn = (full_scale - lvl_dev) * longint'(it.saturation);
            offset = (2 * longint'(it.level) * full_scale - cn) * turn;
        end
        else
        begin
            cn = longint'(it.level) * longint'(it.saturation);
            offset = (longint'(it.level) * full_scale - cn) * 2 * turn;
        end
        chroma = cn * 2 * turn;
        xval = cn * ramp * 2;
        case (sext)
            SEXT_RED:
            begin
                r = chroma; g = xval; b = 0;
            end
            SEXT_YELLOW:
            begin
                r = xval; g = chroma; b = 0;
            end
            SEXT_GREEN:
            begin
                r = 0; g = chroma; b = xval;
            end
            SEXT_CYAN:
            begin
                r = 0; g = xval; b = chroma;
            end
            SEXT_BLUE:
            begin
                r = xval; g = 0; b = chroma;
            end
            default:
            begin
                r = chroma; g = 0; b = xval;
            end
        endcase
        res.red = scale_channel(r + offset);
        res.green = scale_channel(g + offset);
        res.blue = scale_channel(b + offset);
        return res;
    endfunction

    function automatic hsx_item_t make_hsx(logic mode, int hue, int sat, int lvl);
        hsx_item_t it;
        it.req_type = mode;
        it.hue = HUE_BITS'(hue);
        it.saturation = CHANNEL_BITS'(sat);
        it.level = CHANNEL_BITS'(lvl);
        return it;
    endfunction

    function automatic int pick_fraction();
        int v;
        case ($urandom_range(9))
            0: v = 0;
            1: v = CH_FULL;
            2: v = 127 + $urandom_range(1);
            default: v = $urandom_range(CH_FULL);
        endcase
        return v;
    endfunction

    function automatic hsx_item_t random_hsx();
        int hue;
        if ($urandom_range(3) == 0)
        begin
            // Land on or beside a sextant boundary.
            hue = ($urandom_range(6) * (1 << HUE_BITS) + 5) / 6 + $urandom_range(2) - 1;
        end
        else
        begin
            hue = $urandom;
        end
        return make_hsx(1'($urandom_range(1)), hue, pick_fraction(), pick_fraction());
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                in_flight_hsx.push_back(hsx);
            end
            if (!push || !full)
            begin
                if (pending_hsx.size() > 0 && $urandom_range(99) >= tx_idle)
                begin
                    push <= 1'b1;
                    hsx <= pending_hsx.pop_front();
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        hsx_item_t sent;
        rgb_item_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (in_flight_hsx.size() == 0)
                begin
                    if (fault_count < 10)
                    begin
                        $display("unexpected result r=%0d g=%0d b=%0d at %0t",
                                 rgb.red, rgb.green, rgb.blue, $realtime);
                    end
                    fault_count++;
                end
                else
                begin
                    sent = in_flight_hsx.pop_front();
                    want = convert_hsx(sent);
                    if (rgb !== want)
                    begin
                        if (fault_count < 10)
                        begin
                            $display("mismatch for mode=%0d hue=%0d sat=%0d lvl=%0d: %s",
                                     sent.req_type, sent.hue, sent.saturation, sent.level,
                                     $sformatf("expected %0d/%0d/%0d got %0d/%0d/%0d",
                                               want.red, want.green, want.blue,
                                               rgb.red, rgb.green, rgb.blue));
                        end
                        fault_count++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= rx_idle);
        end
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int edge_hues[11];
        edge_hues = '{0, 10922, 10923, 21845, 21846, 32768, 43690, 43691,
                      54613, 54614, 65535};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (edge_hues[i])
        begin
            pending_hsx.push_back(make_hsx(MODE_HSV, edge_hues[i], CH_FULL, CH_FULL));
            pending_hsx.push_back(make_hsx(MODE_HSL, edge_hues[i], CH_FULL, 127 + i % 2));
        end
        pending_hsx.push_back(make_hsx(MODE_HSV, 5000, 0, CH_FULL));
        pending_hsx.push_back(make_hsx(MODE_HSL, 30000, CH_FULL, 0));
        pending_hsx.push_back(make_hsx(MODE_HSL, 50000, CH_FULL, CH_FULL));
        repeat (600) pending_hsx.push_back(random_hsx());

        // Hold the next phase back until the block has handed out every result.
        while (pending_hsx.size() != 0 || push || in_flight_hsx.size() != 0)
        begin
            @(negedge clk);
        end

        tx_idle = 61;
        rx_idle = 28;
        repeat (600) pending_hsx.push_back(random_hsx());
        while (pending_hsx.size() != 0)
        begin
            @(negedge clk);
        end

        tx_idle = 0;
        rx_idle = 0;
        repeat (500) pending_hsx.push_back(random_hsx());
        while (pending_hsx.size() != 0 || push || in_flight_hsx.size() != 0)
        begin
            @(negedge clk);
        end

        repeat (12) @(posedge clk);
        if (fault_count == 0 && in_flight_hsx.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
